/* sv/npc_pkg.sv */
// ----------------------------------------------------------------------------
// npc_pkg: shared types and helpers for the nearest palette colour search
// Beat layout carried down the cell chain, widths and the distance function.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W         = 9;
  localparam int CMP_W         = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int DIST_W        = 18;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        entry_index;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        best_idx;
    logic [DIST_W-1:0] best_d;
    logic              found;
  } npc_beat_t;

  function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {8'd0, d} * {8'd0, d};
  endfunction

  // low 8 bits of a cell number
  function automatic logic [7:0] idx8(input logic [IDX_W-1:0] i);
    logic [IDX_W+7:0] t;
    t = {8'd0, i};
    return t[7:0];
  endfunction

endpackage

/* sv/npc_cell.sv */
// ----------------------------------------------------------------------------
// npc_cell: one palette slot of the search chain
// Holds one entry, captures it on a matching load, folds its distance into
// the running best of a passing query if below count and hands the beat on.
// ----------------------------------------------------------------------------
module npc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [npc_pkg::IDX_W-1:0] cell_id,
  input  logic [npc_pkg::CNT_W-1:0] count,
  input  logic                     vld_i,
  input  npc_pkg::npc_beat_t       beat_i,
  output logic                     vld_o,
  output npc_pkg::npc_beat_t       beat_o
);

  logic [23:0]                 entry_r;
  logic                        vld_r;
  npc_pkg::npc_beat_t          beat_r;
  npc_pkg::npc_beat_t          beat_nxt;
  logic                        load_hit;
  logic                        active;
  logic [npc_pkg::DIST_W-1:0]  cand_d;
  logic [npc_pkg::CMP_W-1:0]   id_ext;

  assign id_ext   = npc_pkg::CMP_W'(cell_id);
  assign load_hit = vld_i && (beat_i.cmd == npc_pkg::CMD_LOAD) &&
                    (npc_pkg::CMP_W'(beat_i.entry_index) == id_ext);
  // cell_id < DEPTH always, so this also saturates the count
  assign active   = id_ext < npc_pkg::CMP_W'(count);

  assign cand_d = npc_pkg::DIST_W'(npc_pkg::chan_sq(beat_i.red,   entry_r[23:16]))
                + npc_pkg::DIST_W'(npc_pkg::chan_sq(beat_i.green, entry_r[15:8]))
                + npc_pkg::DIST_W'(npc_pkg::chan_sq(beat_i.blue,  entry_r[7:0]));

  always_comb begin
    beat_nxt = beat_i;
    if (beat_i.cmd == npc_pkg::CMD_QUERY && active &&
        (!beat_i.found || cand_d < beat_i.best_d)) begin
      beat_nxt.best_idx = npc_pkg::idx8(cell_id);
      beat_nxt.best_d   = cand_d;
      beat_nxt.found    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat_r <= beat_nxt;
      if (load_hit) begin
        entry_r <= {beat_i.red, beat_i.green, beat_i.blue};
      end
    end
  end

  assign vld_o  = vld_r;
  assign beat_o = beat_r;

endmodule

/* sv/nearest_palette_color.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color: nearest palette colour by squared Euclidean distance
// Systolic chain of palette cells with a streaming front and back end.
// ----------------------------------------------------------------------------
// Every input beat, load or query, enters a chain of PALETTE_DEPTH cells, one
// cell per palette slot, and moves one cell per cycle. A load is captured by
// the cell whose number equals entry_index (an index beyond the depth matches
// no cell and is dropped); a query picks up, in each of the first
// palette_count cells, the distance to that cell's entry and keeps the lowest
// index of the smallest distance. Because loads travel the same chain, every
// query sees exactly the loads accepted before it. A query leaves after it
// has passed every cell register, and one beat can be accepted every cycle;
// the whole chain holds while a result waits on out_tready, so the rate is
// one beat per cycle less any stall cycles at the output. Load beats give no
// result. palette_count may only be written while no beat is in the chain.
// An empty search returns index 0, distance 0, found 0. Palette slots are not
// cleared by reset: searching a slot never loaded gives an undefined result.
// ----------------------------------------------------------------------------
module nearest_palette_color (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,   // palette_count
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // entry_index[7:0], red, green, blue
  input  logic        in_tuser,      // command: 0 load, 1 query
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // nearest_index[7:0], distance[25:8], zero pad
  output logic        out_tuser      // found
);

  localparam int N = npc_pkg::PALETTE_DEPTH;

  logic [npc_pkg::CNT_W-1:0] count_r;
  logic                      adv;
  logic                      vld_l  [N+1];
  npc_pkg::npc_beat_t        beat_l [N+1];
  npc_pkg::npc_beat_t        head;
  npc_pkg::npc_beat_t        tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // whole chain advances unless a query result sits unaccepted at the tail
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_comb begin
    head             = '0;
    head.cmd         = in_tuser;
    head.entry_index = in_tdata[7:0];
    head.red         = in_tdata[15:8];
    head.green       = in_tdata[23:16];
    head.blue        = in_tdata[31:24];
  end
  assign beat_l[0] = head;
  assign vld_l[0]  = in_tvalid;

  for (genvar g = 0; g < N; g++) begin : g_cell
    npc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .cell_id (npc_pkg::IDX_W'(g)),
      .count   (count_r),
      .vld_i   (vld_l[g]),
      .beat_i  (beat_l[g]),
      .vld_o   (vld_l[g+1]),
      .beat_o  (beat_l[g+1])
    );
  end

  // loads fall off the tail unseen
  assign tail       = beat_l[N];
  assign out_tvalid = vld_l[N] && (tail.cmd == npc_pkg::CMD_QUERY);
  assign out_tdata  = {6'd0, tail.best_d, tail.best_idx};
  assign out_tuser  = tail.found;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_l[1])
    else $error("accepted beat did not enter the first cell");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (tail.best_idx == 8'd0 && tail.best_d == '0))
    else $error("empty search returned non-zero index or distance");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(tail) && vld_l[N]))
    else $error("chain moved while stalled");

endmodule
